// File: rtl/core/sphere_sphere_contact_macros.svh
// assertion helpers for the rtl, included by ssc_point
`ifndef SPHERE_SPHERE_CONTACT_MACROS_SVH
`define SPHERE_SPHERE_CONTACT_MACROS_SVH
`ifndef SYNTHESIS
`define SSC_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssc assertion failed");
`define SSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssc assertion failed");
`else
`define SSC_ASSERT(lbl, ante, cons)
`define SSC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/core/ssc_pkg.sv
package ssc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CW = 32;   // coordinate width
  localparam int DW = 33;   // centre difference width
  localparam int RW = 31;   // radius width
  localparam int LW = 32;   // distance width
  localparam int NW = 18;   // normal field width

  typedef struct packed {
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] dz;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] bz;
    logic [LW-1:0]        rsum;
    logic [RW-1:0]        rb;
    logic                 stat_a;
    logic                 stat_b;
    logic                 hit;
  } pair_t;

  typedef struct packed {
    logic [RW-1:0]        pen;
    logic signed [CW-1:0] k;
    logic [2:0]           sgn;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] bz;
    logic                 stat_a;
    logic                 stat_b;
    logic                 hit;
    logic                 lz;
  } divc_t;

  typedef struct packed {
    logic          has_contact;
    logic [NW-1:0] nx;
    logic [NW-1:0] ny;
    logic [NW-1:0] nz;
    logic [RW-1:0] pen;
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic [CW-1:0] pz;
    logic          first_body;
    logic          second_body;
  } res_t;

  function automatic logic [LW-1:0] mag33(logic signed [DW-1:0] v);
    logic [DW-1:0] t;
    t = v[DW-1] ? DW'(-v) : DW'(v);
    return t[LW-1:0];
  endfunction

endpackage

// File: rtl/core/sphere_sphere_contact.sv
// channel  dir  data bits                      side bits
// in_      in   centres, radii, contacts_left  tuser: flags_a, flags_b
// out_     out  normal, penetration, point,    tuser: has_contact
//               body present bits
// fully pipelined: one item per cycle while the output is not stalled; the square root
// takes 16 stages at two root bits each
// and the normal divide two quotient bits per stage
// rst_n clears the stage valid bits only
// every stage holds while the one after it is full and stalled; empty stages close up
module sphere_sphere_contact #(
  parameter int FRAC_BITS = ssc_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // centre_a_x, centre_a_y, centre_a_z, centre_b_x, centre_b_y, centre_b_z,
  // radius_a, radius_b, contacts_left, zero pad
  input  logic [271:0] in_tdata,
  // flags_a, flags_b
  input  logic [3:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // normal_x, normal_y, normal_z, penetration, point_x, point_y, point_z,
  // first_body_present, second_body_present, zero pad
  output logic [183:0] out_tdata,
  // has_contact
  output logic [0:0]   out_tuser
);

  logic           pr_valid, pr_ready, sq_valid, sq_ready, dv_valid, dv_ready;
  ssc_pkg::pair_t pr_pair, sq_pair;
  logic [63:0]    pr_sq;
  logic [31:0]    sq_len;
  logic [FRAC_BITS:0] dv_q [3];
  ssc_pkg::divc_t dv_c;
  ssc_pkg::res_t  res;

  ssc_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .cax       (signed'(in_tdata[31:0])),
    .cay       (signed'(in_tdata[63:32])),
    .caz       (signed'(in_tdata[95:64])),
    .cbx       (signed'(in_tdata[127:96])),
    .cby       (signed'(in_tdata[159:128])),
    .cbz       (signed'(in_tdata[191:160])),
    .ra        (in_tdata[222:192]),
    .rb        (in_tdata[253:223]),
    .fa        (in_tuser[1:0]),
    .fb        (in_tuser[3:2]),
    .left      (in_tdata[269:254]),
    .out_valid (pr_valid),
    .out_ready (pr_ready),
    .out_pair  (pr_pair),
    .out_sq    (pr_sq)
  );

  ssc_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pr_valid),
    .in_ready  (pr_ready),
    .in_pair   (pr_pair),
    .in_sq     (pr_sq),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .out_pair  (sq_pair),
    .out_len   (sq_len)
  );

  ssc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .in_ready  (sq_ready),
    .in_pair   (sq_pair),
    .in_len    (sq_len),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_q     (dv_q),
    .out_c     (dv_c)
  );

  ssc_point #(.FRAC_BITS(FRAC_BITS)) u_point (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv_valid),
    .in_ready  (dv_ready),
    .in_q      (dv_q),
    .in_c      (dv_c),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {1'b0, res.second_body, res.first_body, res.pz, res.py, res.px,
                      res.pen, res.nz, res.ny, res.nx};
  assign out_tuser = res.has_contact;

endmodule

// File: rtl/core/ssc_prep.sv
module ssc_prep (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [31:0]    cax,
  input  logic signed [31:0]    cay,
  input  logic signed [31:0]    caz,
  input  logic signed [31:0]    cbx,
  input  logic signed [31:0]    cby,
  input  logic signed [31:0]    cbz,
  input  logic [30:0]           ra,
  input  logic [30:0]           rb,
  input  logic [1:0]            fa,
  input  logic [1:0]            fb,
  input  logic [15:0]           left,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ssc_pkg::pair_t        out_pair,
  output logic [63:0]           out_sq
);

  logic v0_r, v1_r, v2_r;
  logic rdy0, rdy1, rdy2;
  ssc_pkg::pair_t p0_nxt, p0_r, p1_r, p2_r, p2_nxt;
  logic [63:0] sq_r [3];
  logic [63:0] rsq_r;
  logic [63:0] s2_r;
  logic [65:0] sum_nxt;

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign rdy0     = !v0_r || rdy1;
  assign in_ready = rdy0;

  always_comb begin
    p0_nxt.dx     = 33'(cax) - 33'(cbx);
    p0_nxt.dy     = 33'(cay) - 33'(cby);
    p0_nxt.dz     = 33'(caz) - 33'(cbz);
    p0_nxt.bx     = cbx;
    p0_nxt.by     = cby;
    p0_nxt.bz     = cbz;
    p0_nxt.rsum   = 32'(ra) + 32'(rb);
    p0_nxt.rb     = rb;
    p0_nxt.stat_a = fa[1];
    p0_nxt.stat_b = fb[1];
    // early reject: no slots, nobody awake, or both static
    p0_nxt.hit    = (left != 16'd0) && (fa[0] || fb[0]) && !(fa[1] && fb[1]);
  end

  assign sum_nxt = 66'(sq_r[0]) + 66'(sq_r[1]) + 66'(sq_r[2]);

  always_comb begin
    p2_nxt     = p1_r;
    p2_nxt.hit = p1_r.hit && (sum_nxt < 66'(rsq_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) p0_r <= p0_nxt;
    if (rdy1) begin
      p1_r     <= p0_r;
      sq_r[0]  <= ssc_pkg::mag33(p0_r.dx) * ssc_pkg::mag33(p0_r.dx);
      sq_r[1]  <= ssc_pkg::mag33(p0_r.dy) * ssc_pkg::mag33(p0_r.dy);
      sq_r[2]  <= ssc_pkg::mag33(p0_r.dz) * ssc_pkg::mag33(p0_r.dz);
      rsq_r    <= p0_r.rsum * p0_r.rsum;
    end
    if (rdy2) begin
      p2_r     <= p2_nxt;
      s2_r     <= sum_nxt[63:0];
    end
  end

  assign out_valid = v2_r;
  assign out_pair  = p2_r;
  assign out_sq    = s2_r;

endmodule

// File: rtl/core/ssc_sqrt.sv
module ssc_sqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ssc_pkg::pair_t in_pair,
  input  logic [63:0]    in_sq,
  output logic           out_valid,
  input  logic           out_ready,
  output ssc_pkg::pair_t out_pair,
  output logic [31:0]    out_len
);

  // two root bits per stage
  localparam int NS = ssc_pkg::LW / 2;

  logic           v_r    [NS];
  logic [35:0]    rem_r  [NS];
  logic [31:0]    root_r [NS];
  logic [63:0]    x_r    [NS];
  ssc_pkg::pair_t p_r    [NS];
  logic           rdy    [NS+1];

  assign rdy[NS]  = out_ready;
  assign in_ready = rdy[0];

  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic           v_i;
    logic [35:0]    rem_i, rem_t, sh, tr;
    logic [31:0]    root_i, root_t;
    logic [63:0]    x_i, x_t;
    ssc_pkg::pair_t p_i;

    assign rdy[g] = !v_r[g] || rdy[g+1];

    if (g == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = '0;
      assign root_i = '0;
      assign x_i    = in_sq;
      assign p_i    = in_pair;
    end else begin : g_next
      assign v_i    = v_r[g-1];
      assign rem_i  = rem_r[g-1];
      assign root_i = root_r[g-1];
      assign x_i    = x_r[g-1];
      assign p_i    = p_r[g-1];
    end

    always_comb begin
      rem_t  = rem_i;
      root_t = root_i;
      x_t    = x_i;
      sh     = '0;
      tr     = '0;
      for (int j = 0; j < 2; j++) begin
        sh = {rem_t[33:0], x_t[63:62]};
        tr = {2'b00, root_t, 2'b01};
        if (sh >= tr) begin
          rem_t  = sh - tr;
          root_t = {root_t[30:0], 1'b1};
        end else begin
          rem_t  = sh;
          root_t = {root_t[30:0], 1'b0};
        end
        x_t = {x_t[61:0], 2'b00};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (rdy[g]) begin
        v_r[g] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[g]) begin
        rem_r[g]  <= rem_t;
        root_r[g] <= root_t;
        x_r[g]    <= x_t;
        p_r[g]    <= p_i;
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_pair  = p_r[NS-1];
  assign out_len   = root_r[NS-1];

endmodule

// File: rtl/core/ssc_div.sv
module ssc_div #(
  parameter int FRAC_BITS = ssc_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ssc_pkg::pair_t       in_pair,
  input  logic [31:0]          in_len,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FRAC_BITS:0]   out_q [3],
  output ssc_pkg::divc_t       out_c
);

  localparam int QW    = FRAC_BITS + 1;
  localparam int NSTEP = FRAC_BITS + 1;
  localparam int NDS   = (NSTEP + 1) / 2;

  // setup stage
  logic           vp_r;
  ssc_pkg::divc_t cp_r;
  logic [31:0]    lenp_r;
  logic [32:0]    rp_r [3];
  ssc_pkg::divc_t cp_nxt;
  logic [31:0]    diff;
  logic           rdyp;

  logic           v_r   [NDS];
  ssc_pkg::divc_t c_r   [NDS];
  logic [31:0]    len_r [NDS];
  logic [32:0]    r_r   [NDS][3];
  logic [QW-1:0]  q_r   [NDS][3];
  logic           rdy   [NDS+1];

  assign rdy[NDS] = out_ready;
  assign rdyp     = !vp_r || rdy[0];
  assign in_ready = rdyp;

  always_comb begin
    diff          = in_pair.rsum - in_len;
    cp_nxt.pen    = diff[31:1];
    cp_nxt.k      = signed'({1'b0, in_pair.rb}) - signed'({1'b0, diff[31:1]});
    cp_nxt.sgn    = {in_pair.dz[32], in_pair.dy[32], in_pair.dx[32]};
    cp_nxt.bx     = in_pair.bx;
    cp_nxt.by     = in_pair.by;
    cp_nxt.bz     = in_pair.bz;
    cp_nxt.stat_a = in_pair.stat_a;
    cp_nxt.stat_b = in_pair.stat_b;
    cp_nxt.hit    = in_pair.hit;
    cp_nxt.lz     = (in_len == 32'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
    end else if (rdyp) begin
      vp_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdyp) begin
      cp_r    <= cp_nxt;
      lenp_r  <= in_len;
      rp_r[0] <= {1'b0, ssc_pkg::mag33(in_pair.dx)};
      rp_r[1] <= {1'b0, ssc_pkg::mag33(in_pair.dy)};
      rp_r[2] <= {1'b0, ssc_pkg::mag33(in_pair.dz)};
    end
  end

  for (genvar g = 0; g < NDS; g++) begin : g_stage
    logic           v_i;
    ssc_pkg::divc_t c_i;
    logic [31:0]    len_i;
    logic [32:0]    r_i [3];
    logic [QW-1:0]  q_i [3];
    logic [32:0]    r_t [3];
    logic [QW-1:0]  q_t [3];
    logic [32:0]    t;
    logic           qb;

    assign rdy[g] = !v_r[g] || rdy[g+1];

    if (g == 0) begin : g_first
      assign v_i   = vp_r;
      assign c_i   = cp_r;
      assign len_i = lenp_r;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign r_i[l] = rp_r[l];
        assign q_i[l] = '0;
      end
    end else begin : g_next
      assign v_i   = v_r[g-1];
      assign c_i   = c_r[g-1];
      assign len_i = len_r[g-1];
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign r_i[l] = r_r[g-1][l];
        assign q_i[l] = q_r[g-1][l];
      end
    end

    // the remainder stays below len after the first step, so doubling fits 33 bits
    always_comb begin
      t  = '0;
      qb = 1'b0;
      for (int l = 0; l < 3; l++) begin
        r_t[l] = r_i[l];
        q_t[l] = q_i[l];
        for (int j = 0; j < 2; j++) begin
          if (2 * g + j < NSTEP) begin
            t  = (2 * g + j == 0) ? r_t[l] : {r_t[l][31:0], 1'b0};
            qb = (t >= {1'b0, len_i});
            r_t[l] = qb ? (t - {1'b0, len_i}) : t;
            q_t[l] = {q_t[l][QW-2:0], qb};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (rdy[g]) begin
        v_r[g] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[g]) begin
        c_r[g]   <= c_i;
        len_r[g] <= len_i;
        for (int l = 0; l < 3; l++) begin
          r_r[g][l] <= r_t[l];
          q_r[g][l] <= q_t[l];
        end
      end
    end
  end

  assign out_valid = v_r[NDS-1];
  assign out_c     = c_r[NDS-1];
  assign out_q[0]  = q_r[NDS-1][0];
  assign out_q[1]  = q_r[NDS-1][1];
  assign out_q[2]  = q_r[NDS-1][2];

endmodule

// File: rtl/core/ssc_point.sv
`include "sphere_sphere_contact_macros.svh"

module ssc_point #(
  parameter int FRAC_BITS = ssc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FRAC_BITS:0] in_q [3],
  input  ssc_pkg::divc_t     in_c,
  output logic               out_valid,
  input  logic               out_ready,
  output ssc_pkg::res_t      out_res
);

  localparam int QW = FRAC_BITS + 1;
  localparam int PW = QW + 31;

  logic           va_r, vb_r;
  logic           rdy_a, rdy_b;
  ssc_pkg::divc_t c_a_r;
  logic [PW-1:0]  prod_r [3];
  logic [17:0]    nrm_r  [3];
  logic [QW-1:0]  nmag   [3];
  logic [QW:0]    nneg   [3];
  logic signed [QW:0] nf [3];
  logic [31:0]    kmag;
  logic [31:0]    pm     [3];
  logic signed [33:0] off [3];
  logic signed [33:0] sum [3];
  logic [31:0]    sat    [3];
  logic signed [31:0] bsel [3];
  ssc_pkg::res_t  res_nxt, res_r;

  assign rdy_b    = !vb_r || out_ready;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;

  always_comb begin
    kmag = in_c.k[31] ? 32'(-in_c.k) : 32'(in_c.k);
    for (int i = 0; i < 3; i++) begin
      // coincident centres give a zero normal
      nmag[i] = in_c.lz ? '0 : in_q[i];
      nneg[i] = (QW + 1)'(-{1'b0, nmag[i]});
      nf[i]   = in_c.sgn[i] ? signed'(nneg[i]) : signed'({1'b0, nmag[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_valid;
      if (rdy_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      c_a_r <= in_c;
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= PW'(nmag[i]) * PW'(kmag[30:0]);
        nrm_r[i]  <= 18'(nf[i]);
      end
    end
  end

  always_comb begin
    bsel[0] = c_a_r.bx;
    bsel[1] = c_a_r.by;
    bsel[2] = c_a_r.bz;
    for (int i = 0; i < 3; i++) begin
      pm[i]  = prod_r[i][PW-1:FRAC_BITS];
      off[i] = (c_a_r.sgn[i] ^ c_a_r.k[31]) ? -signed'({2'b00, pm[i]})
                                             : signed'({2'b00, pm[i]});
      sum[i] = 34'(bsel[i]) + off[i];
      if (sum[i] > 34'sh0_7FFF_FFFF) begin
        sat[i] = 32'h7FFF_FFFF;
      end else if (sum[i] < -34'sh0_8000_0000) begin
        sat[i] = 32'h8000_0000;
      end else begin
        sat[i] = sum[i][31:0];
      end
    end
    res_nxt = '0;
    if (c_a_r.hit) begin
      res_nxt.has_contact = 1'b1;
      res_nxt.nx          = nrm_r[0];
      res_nxt.ny          = nrm_r[1];
      res_nxt.nz          = nrm_r[2];
      res_nxt.pen         = c_a_r.pen;
      res_nxt.px          = sat[0];
      res_nxt.py          = sat[1];
      res_nxt.pz          = sat[2];
      res_nxt.first_body  = !c_a_r.stat_a;
      res_nxt.second_body = !c_a_r.stat_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b) res_r <= res_nxt;
  end

  assign out_valid = vb_r;
  assign out_res   = res_r;

  `SSC_ASSERT(a_miss_zero, vb_r && !res_r.has_contact, res_r == '0)
  `SSC_ASSERT(a_hit_body, vb_r && res_r.has_contact, res_r.first_body || res_r.second_body)
  `SSC_ASSERT(a_lz_normal, va_r && c_a_r.lz, nrm_r[0] == '0 && nrm_r[1] == '0 && nrm_r[2] == '0)
  `SSC_ASSERT_NEXT(a_stage_hold, va_r && !rdy_a, va_r && $stable(prod_r[0]))

endmodule

// File: verif/sphere_sphere_contact_tb.sv
module sphere_sphere_contact_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = ssc_pkg::FRAC_BITS_DEF;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic signed [31:0] ax, ay, az, bx, by, bz;
    logic [30:0]        ra, rb;
    logic [1:0]         fa, fb;
    logic [15:0]        left;
  } sphere_pair_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [271:0] in_tdata = '0;
  logic [3:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [183:0] out_tdata;
  logic [0:0]   out_tuser;

  sphere_pair_t  pending_pairs[$];
  ssc_pkg::res_t contact_queue[$];
  sphere_pair_t  offered;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  int           errors = 0;
  int           pairs_in = 0;
  int           results_out = 0;
  int           contacts_seen = 0;
  int           idle_cycles = 0;
  bit           hold_req = 0;
  bit           hold_done = 0;
  int           hold_cnt = 0;

  sphere_sphere_contact u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x = x - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic ssc_pkg::res_t predict_contact(sphere_pair_t p);
    ssc_pkg::res_t   r;
    longint          d[3], b[3], n[3], k, off, pt;
    longint unsigned m, q, len, rsum, pen, pm;
    logic [127:0]    dist_sq, rad_sq;
    bit              stat_a, stat_b;
    r = '0;
    stat_a = p.fa[1];
    stat_b = p.fb[1];
    if (p.left == 0 || (!p.fa[0] && !p.fb[0]) || (stat_a && stat_b)) return r;
    b[0] = p.bx; b[1] = p.by; b[2] = p.bz;
    d[0] = longint'(p.ax) - b[0];
    d[1] = longint'(p.ay) - b[1];
    d[2] = longint'(p.az) - b[2];
    dist_sq = 0;
    for (int i = 0; i < 3; i++) begin
      m = d[i] < 0 ? -d[i] : d[i];
      dist_sq = dist_sq + 128'(m) * 128'(m);
    end
    rsum = 64'(p.ra) + 64'(p.rb);
    rad_sq = 128'(rsum) * 128'(rsum);
    if (dist_sq >= rad_sq) return r;
    len = root_floor(dist_sq[63:0]);
    for (int i = 0; i < 3; i++) begin
      q = 0;
      if (len != 0) begin
        m = d[i] < 0 ? -d[i] : d[i];
        q = (m << FB) / len;
        if (q > (64'd1 << FB)) q = 64'd1 << FB;
      end
      n[i] = d[i] < 0 ? -longint'(q) : longint'(q);
    end
    pen = (rsum - len) >> 1;
    k = longint'(p.rb) - longint'(pen);
    r.has_contact = 1'b1;
    r.nx = n[0][ssc_pkg::NW-1:0];
    r.ny = n[1][ssc_pkg::NW-1:0];
    r.nz = n[2][ssc_pkg::NW-1:0];
    r.pen = pen[ssc_pkg::RW-1:0];
    for (int i = 0; i < 3; i++) begin
      pm = ((n[i] < 0 ? -n[i] : n[i]) * (k < 0 ? -k : k)) >> FB;
      off = ((n[i] < 0) != (k < 0)) ? -longint'(pm) : longint'(pm);
      pt = b[i] + off;
      if (pt > 64'sd2147483647) pt = 64'sd2147483647;
      if (pt < -64'sd2147483648) pt = -64'sd2147483648;
      if (i == 0) r.px = pt[31:0];
      else if (i == 1) r.py = pt[31:0];
      else r.pz = pt[31:0];
    end
    r.first_body = !stat_a;
    r.second_body = !stat_b;
    return r;
  endfunction

  function automatic sphere_pair_t mk_pair(longint ax, longint ay, longint az, longint bx,
                                           longint by, longint bz, longint ra, longint rb,
                                           int fa, int fb, int left);
    sphere_pair_t p;
    p.ax = ax[31:0]; p.ay = ay[31:0]; p.az = az[31:0];
    p.bx = bx[31:0]; p.by = by[31:0]; p.bz = bz[31:0];
    p.ra = ra[30:0]; p.rb = rb[30:0];
    p.fa = fa[1:0]; p.fb = fb[1:0]; p.left = left[15:0];
    return p;
  endfunction

  function automatic sphere_pair_t random_pair();
    sphere_pair_t p;
    longint       span, bc[3], ac[3];
    int           sc;
    if ($urandom_range(99) < 15) begin
      // raw noise over the full field ranges
      p = mk_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom_range(3), $urandom_range(3), $urandom);
      return p;
    end
    sc = $urandom_range(30, 2);
    p.ra = 31'($urandom_range((1 << sc) - 1));
    p.rb = 31'($urandom_range((1 << sc) - 1));
    span = (longint'(p.ra) + longint'(p.rb)) * 3 / 5 + 1;
    for (int i = 0; i < 3; i++) begin
      bc[i] = longint'(signed'($urandom));
      if ($urandom_range(3) == 0) bc[i] = bc[i] >>> $urandom_range(31);
      ac[i] = bc[i] + longint'($urandom_range(32'(2 * span))) - span;
    end
    if ($urandom_range(19) == 0) begin
      ac[0] = bc[0]; ac[1] = bc[1]; ac[2] = bc[2];
    end
    p = mk_pair(ac[0], ac[1], ac[2], bc[0], bc[1], bc[2], p.ra, p.rb,
                $urandom_range(3), $urandom_range(3),
                $urandom_range(19) == 0 ? 0 : $urandom_range(65535, 1));
    if ($urandom_range(3) != 0) p.fa[0] = 1'b1;
    return p;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on result %0d: %s got %0h expected %0h", results_out, what, got, want);
    errors++;
  endtask

  // driver: next item offered once the current one has gone or none is up
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        contact_queue.push_back(predict_contact(offered));
        pairs_in++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = pending_pairs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {2'b00, offered.left, offered.rb, offered.ra, offered.bz, offered.by,
                       offered.bx, offered.az, offered.ay, offered.ax};
          in_tuser <= {offered.fb, offered.fa};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver, with one long hold-off to back the pipeline up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      out_tready <= 1'b0;
      hold_cnt++;
      if (hold_cnt >= HOLD_CYCLES) hold_done = 1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    ssc_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (contact_queue.size() == 0) begin
        report_mismatch("unexpected result", out_tuser[0], 0);
      end else begin
        want = contact_queue.pop_front();
        if (want.has_contact) contacts_seen++;
        if (out_tuser[0] !== want.has_contact)
          report_mismatch("has_contact", out_tuser[0], want.has_contact);
        if (out_tdata[17:0] !== want.nx) report_mismatch("normal_x", out_tdata[17:0], want.nx);
        if (out_tdata[35:18] !== want.ny) report_mismatch("normal_y", out_tdata[35:18], want.ny);
        if (out_tdata[53:36] !== want.nz) report_mismatch("normal_z", out_tdata[53:36], want.nz);
        if (out_tdata[84:54] !== want.pen)
          report_mismatch("penetration", out_tdata[84:54], want.pen);
        if (out_tdata[116:85] !== want.px) report_mismatch("point_x", out_tdata[116:85], want.px);
        if (out_tdata[148:117] !== want.py)
          report_mismatch("point_y", out_tdata[148:117], want.py);
        if (out_tdata[180:149] !== want.pz)
          report_mismatch("point_z", out_tdata[180:149], want.pz);
        if (out_tdata[181] !== want.first_body)
          report_mismatch("first_body_present", out_tdata[181], want.first_body);
        if (out_tdata[182] !== want.second_body)
          report_mismatch("second_body_present", out_tdata[182], want.second_body);
      end
      results_out++;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("stalled: no item moved for %0d cycles", IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic drain();
    @(posedge clk);
    while (pending_pairs.size() > 0 || in_tvalid || contact_queue.size() > 0) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners
    pending_pairs.push_back(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(mk_pair(-1, -1, -1, -1, -1, -1, 2147483647, 2147483647, 3, 3, 65535));
    pending_pairs.push_back(mk_pair(100, 0, 0, 0, 0, 0, 65536, 65536, 1, 1, 0));
    pending_pairs.push_back(mk_pair(100, 0, 0, 0, 0, 0, 65536, 65536, 2, 0, 5));
    pending_pairs.push_back(mk_pair(100, 0, 0, 0, 0, 0, 65536, 65536, 3, 3, 5));
    pending_pairs.push_back(mk_pair(100, 0, 0, 0, 0, 0, 65536, 65536, 1, 0, 1));
    pending_pairs.push_back(mk_pair(100, 0, 0, 0, 0, 0, 65536, 65536, 0, 1, 1));
    pending_pairs.push_back(mk_pair(100, 0, 0, 0, 0, 0, 65536, 65536, 3, 1, 1));
    pending_pairs.push_back(mk_pair(100, 0, 0, 0, 0, 0, 65536, 65536, 1, 3, 1));
    // coincident centres
    pending_pairs.push_back(mk_pair(777, -5, 9, 777, -5, 9, 1000, 1000, 1, 1, 1));
    pending_pairs.push_back(mk_pair(2147483647, -2147483648, 0, 2147483647, -2147483648, 0,
                                    2147483647, 2147483647, 1, 1, 65535));
    // exact touch and just inside
    pending_pairs.push_back(mk_pair(3000, 0, 0, 0, 0, 0, 1000, 2000, 1, 1, 1));
    pending_pairs.push_back(mk_pair(2999, 0, 0, 0, 0, 0, 1000, 2000, 1, 1, 1));
    pending_pairs.push_back(mk_pair(0, -2999, 0, 0, 0, 0, 1000, 2000, 1, 1, 1));
    pending_pairs.push_back(mk_pair(0, 0, 2999, 0, 0, 0, 1000, 2000, 1, 1, 1));
    // widest separation, largest radii
    pending_pairs.push_back(mk_pair(2147483647, 2147483647, 2147483647, -2147483648, -2147483648,
                                    -2147483648, 2147483647, 2147483647, 1, 1, 1));
    pending_pairs.push_back(mk_pair(2147483647, 0, 0, -2147483648, 0, 0,
                                    2147483647, 2147483647, 1, 1, 1));
    // point saturation both ways
    pending_pairs.push_back(mk_pair(2147483647, 0, 0, 2147483547, 0, 0, 10, 2147483647, 1, 1, 1));
    pending_pairs.push_back(mk_pair(-2147483648, 0, 0, -2147483548, 0, 0, 10, 2147483647, 1, 1, 1));
    // negative k: large radius on a, tiny on b; then a pair with b static and not awake
    pending_pairs.push_back(mk_pair(5, 5, 5, 0, 0, 0, 2147483647, 1, 1, 1, 1));
    pending_pairs.push_back(mk_pair(-65536, 65536, -65536, 0, 0, 0, 1 << 20, 1 << 20, 1, 2, 9));
    for (int i = 0; i < 350; i++) pending_pairs.push_back(random_pair());
    drain();

    for (int ph = 1; ph < 5; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? 53 : 0;
      if (ph == 2) send_idle_pct = 0;
      stall_pct = (ph == 2 || ph == 3) ? 53 : 0;
      if (ph == 3) begin
        send_idle_pct = 34;
        stall_pct = 34;
      end
      if (ph == 4) hold_req = 1;
      for (int i = 0; i < 375; i++) pending_pairs.push_back(random_pair());
      drain();
    end
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (60) @(posedge clk);

    $display("%0d sphere pairs sent under five idle and stall mixes, one long output hold",
             pairs_in);
    $display("%0d results checked, %0d of them contacts, %0d mismatches",
             results_out, contacts_seen, errors);
    if (errors == 0 && contact_queue.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
